[hw/rtl/gbc_pkg.sv]
// Shared types, codes and index tables for the gyro bias calibrator.
package gbc_pkg;

    localparam int RW  = 16;    // rate sample width
    localparam int LW  = 32;    // norm limit width
    localparam int MAW = 64;    // multiplier operand width
    localparam int MPW = 128;   // multiplier product width

    localparam logic [31:0] NORM_LIMIT_RST = 32'd1677722;

    localparam logic [1:0] FN_SAMPLE  = 2'd0;
    localparam logic [1:0] FN_ENABLE  = 2'd1;
    localparam logic [1:0] FN_DISABLE = 2'd2;

    // multiplier operand selects
    localparam logic [2:0] MS_RATE = 3'd0;
    localparam logic [2:0] MS_T1   = 3'd1;
    localparam logic [2:0] MS_T2   = 3'd2;
    localparam logic [2:0] MS_SQ   = 3'd3;
    localparam logic [2:0] MS_NN   = 3'd4;
    localparam logic [2:0] MS_LIM  = 3'd5;
    localparam logic [2:0] MS_MM   = 3'd6;

    localparam logic [2:0] K_FIRST = 3'd0;
    localparam logic [2:0] K_CROSS = 3'd3;  // off-diagonal terms count twice
    localparam logic [2:0] K_LAST  = 3'd5;
    localparam logic [1:0] J_FIRST = 2'd0;
    localparam logic [1:0] J_LAST  = 2'd2;

    typedef struct packed {
        logic       take_in;
        logic       add_axes;
        logic       mul_start;
        logic [2:0] mul_sel;
        logic [2:0] k;
        logic       acc_pr;
        logic       ld_t1;
        logic       ld_d;
        logic       clr_acc;
        logic       acc_sq;
        logic       ld_nn;
        logic       ld_m;
        logic       div_start;
        logic       bias_wr;
        logic [1:0] j;
        logic       clr_sums;
        logic       clr_bias;
        logic       load_out;
        logic       body_en;
        logic       cal;
        logic       calibrating;
        logic       fail;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic gt;
        logic n_ge2;
        logic n_full;
    } t_stat;

    // product order xx, yy, zz, xy, xz, yz
    function automatic logic [1:0] f_ia(input logic [2:0] k);
        case (k)
            3'd0:    f_ia = 2'd0;
            3'd1:    f_ia = 2'd1;
            3'd2:    f_ia = 2'd2;
            3'd3:    f_ia = 2'd0;
            3'd4:    f_ia = 2'd0;
            3'd5:    f_ia = 2'd1;
            default: f_ia = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] f_ib(input logic [2:0] k);
        case (k)
            3'd0:    f_ib = 2'd0;
            3'd1:    f_ib = 2'd1;
            3'd2:    f_ib = 2'd2;
            3'd3:    f_ib = 2'd1;
            3'd4:    f_ib = 2'd2;
            3'd5:    f_ib = 2'd2;
            default: f_ib = 2'd0;
        endcase
    endfunction

endpackage

[hw/rtl/gbc_if.sv]
// Channel interfaces: sample/command input, result output, limit write.
interface gbc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    modport source(output valid, func, rate_x, rate_y, rate_z, input ready);
    modport sink(input valid, func, rate_x, rate_y, rate_z, output ready);
endinterface

interface gbc_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] body_x;
    logic signed [15:0] body_y;
    logic signed [15:0] body_z;
    logic              is_calibrated;
    logic              is_calibrating;
    logic [7:0]        collected;
    logic              run_failed;
    modport source(output valid, body_x, body_y, body_z, is_calibrated, is_calibrating,
                   collected, run_failed, input ready);
    modport sink(input valid, body_x, body_y, body_z, is_calibrated, is_calibrating,
                 collected, run_failed, output ready);
endinterface

interface gbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] norm_limit;
    modport source(output valid, norm_limit, input ready);
    modport sink(input valid, norm_limit, output ready);
endinterface

[hw/rtl/gbc_mul.sv]
// Iterative unsigned multiplier, one 16-bit digit of the second operand per cycle.
module gbc_mul import gbc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [MAW-1:0] i_a,
    input  logic [MAW-1:0] i_b,
    output logic           o_done,
    output logic [MPW-1:0] o_prod
);
    localparam int PPW = MAW + 16;

    logic [MAW-1:0] r_a;
    logic [MAW-1:0] r_b;
    logic [1:0]     r_sh;
    logic           r_busy;
    logic           r_done;
    logic [MPW-1:0] r_acc;
    logic [PPW-1:0] w_pp;
    logic [MPW-1:0] w_sh;
    logic [MAW-1:0] w_bnext;

    assign w_pp    = PPW'(r_a) * PPW'(r_b[15:0]);
    assign w_sh    = MPW'(w_pp) << {r_sh, 4'b0000};
    assign w_bnext = r_b >> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_bnext == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_sh  <= 2'd0;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_sh;
            r_b   <= w_bnext;
            r_sh  <= r_sh + 2'd1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[hw/rtl/gbc_div.sv]
// Restoring divider, one quotient bit per cycle.
module gbc_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W:0]   w_rem_n;

    // remainder stays below the divisor, so the shifted trial fits DEN_W+1 bits
    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_rem_n = w_ge ? w_trial - {1'b0, r_den} : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_ge};
            r_rem <= DEN_W'(w_rem_n);
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

[hw/rtl/gbc_dp.sv]
// Datapath: sums, covariance check arithmetic, bias, limit register and result register.
module gbc_dp import gbc_pkg::*; #(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic signed [RW-1:0]  i_rate_x,
    input  logic signed [RW-1:0]  i_rate_y,
    input  logic signed [RW-1:0]  i_rate_z,
    input  logic                  i_cfg_we,
    input  logic [LW-1:0]         i_cfg_data,
    output logic signed [RW-1:0]  o_body_x,
    output logic signed [RW-1:0]  o_body_y,
    output logic signed [RW-1:0]  o_body_z,
    output logic                  o_is_calibrated,
    output logic                  o_is_calibrating,
    output logic [7:0]            o_collected,
    output logic                  o_run_failed
);
    localparam int NW  = $clog2(HISTORY_DEPTH + 1);
    localparam int AW  = RW + NW;
    localparam int PW  = 2 * RW + NW;
    localparam int NNW = 2 * NW;
    localparam int MW  = LW + 2 * NW;

    logic signed [RW-1:0] r_rate   [3];
    logic signed [AW-1:0] r_sum_ax [3];
    logic signed [PW-1:0] r_sum_pr [6];
    logic signed [RW-1:0] r_bias   [3];
    logic [NW-1:0]        r_cnt;
    logic [LW-1:0]        r_lim;
    logic signed [63:0]   r_t1;
    logic [63:0]          r_dmag;
    logic [MPW-1:0]       r_acc;
    logic [NNW-1:0]       r_nn;
    logic [MW-1:0]        r_m;
    logic                 r_neg;
    logic signed [RW-1:0] r_body [3];
    logic                 r_o_cal;
    logic                 r_o_calibrating;
    logic [7:0]           r_o_coll;
    logic                 r_o_fail;

    logic [RW-1:0]        w_rmag [3];
    logic [AW-1:0]        w_amag [3];
    logic [PW-1:0]        w_pmag [6];
    logic signed [RW:0]   w_diff [3];
    logic signed [RW-1:0] w_sat  [3];
    logic [1:0]           w_ia;
    logic [1:0]           w_ib;
    logic [MAW-1:0]       w_ma;
    logic [MAW-1:0]       w_mb;
    logic                 w_neg;
    logic                 w_mul_done;
    logic [MPW-1:0]       w_prod;
    logic signed [63:0]   w_sprod;
    logic signed [63:0]   w_dd;
    logic [63:0]          w_dmag;
    logic [AW-1:0]        w_num;
    logic                 w_div_done;
    logic [AW-1:0]        w_quo;
    logic [AW-1:0]        w_bq;
    logic [7:0]           w_coll;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rmag[i] = r_rate[i][RW-1] ? RW'(-r_rate[i]) : RW'(r_rate[i]);
            w_amag[i] = r_sum_ax[i][AW-1] ? AW'(-r_sum_ax[i]) : AW'(r_sum_ax[i]);
            w_diff[i] = $signed({r_rate[i][RW-1], r_rate[i]} - {r_bias[i][RW-1], r_bias[i]});
            w_sat[i]  = (w_diff[i][RW] != w_diff[i][RW-1])
                      ? {w_diff[i][RW], {(RW-1){~w_diff[i][RW]}}}
                      : w_diff[i][RW-1:0];
        end
        for (int p = 0; p < 6; p++) begin
            w_pmag[p] = r_sum_pr[p][PW-1] ? PW'(-r_sum_pr[p]) : PW'(r_sum_pr[p]);
        end
    end

    assign w_ia = f_ia(i_cmd.k);
    assign w_ib = f_ib(i_cmd.k);

    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_neg = 1'b0;
        case (i_cmd.mul_sel)
            MS_RATE: begin
                w_ma  = MAW'(w_rmag[w_ia]);
                w_mb  = MAW'(w_rmag[w_ib]);
                w_neg = r_rate[w_ia][RW-1] ^ r_rate[w_ib][RW-1];
            end
            MS_T1: begin
                w_ma  = MAW'(w_pmag[i_cmd.k]);
                w_mb  = MAW'(r_cnt);
                w_neg = r_sum_pr[i_cmd.k][PW-1];
            end
            MS_T2: begin
                w_ma  = MAW'(w_amag[w_ia]);
                w_mb  = MAW'(w_amag[w_ib]);
                w_neg = r_sum_ax[w_ia][AW-1] ^ r_sum_ax[w_ib][AW-1];
            end
            MS_SQ: begin
                w_ma = r_dmag;
                w_mb = r_dmag;
            end
            MS_NN: begin
                w_ma = MAW'(r_cnt);
                w_mb = MAW'(NW'(r_cnt - 1'b1));
            end
            MS_LIM: begin
                w_ma = MAW'(r_nn);
                w_mb = MAW'(r_lim);
            end
            MS_MM: begin
                w_ma = MAW'(r_m);
                w_mb = MAW'(r_m);
            end
            default: begin
                w_ma = '0;
            end
        endcase
    end

    gbc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_sprod = r_neg ? -$signed(w_prod[63:0]) : $signed(w_prod[63:0]);
    assign w_dd    = r_t1 - w_sprod;
    assign w_dmag  = w_dd[63] ? 64'(-w_dd) : 64'(w_dd);

    // round half away from zero: (|S| + n/2) / n
    assign w_num = w_amag[i_cmd.j] + AW'(r_cnt >> 1);

    gbc_div #(.NUM_W(AW), .DEN_W(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_cnt),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_bq   = r_sum_ax[i_cmd.j][AW-1] ? AW'(-w_quo) : w_quo;
    assign w_coll = (32'(r_cnt) > 32'd255) ? 8'd255 : 8'(r_cnt);

    always_comb begin
        o_stat          = '0;
        o_stat.mul_done = w_mul_done;
        o_stat.div_done = w_div_done;
        o_stat.gt       = r_acc > w_prod;
        o_stat.n_ge2    = 32'(r_cnt) >= 32'd2;
        o_stat.n_full   = 32'(r_cnt) >= HISTORY_DEPTH;
    end

    // calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_sum_ax[i] <= '0;
                r_bias[i]   <= '0;
            end
            for (int p = 0; p < 6; p++) begin
                r_sum_pr[p] <= '0;
            end
            r_cnt <= '0;
            r_lim <= NORM_LIMIT_RST;
        end else begin
            if (i_cfg_we) begin
                r_lim <= i_cfg_data;
            end
            if (i_cmd.add_axes) begin
                for (int i = 0; i < 3; i++) begin
                    r_sum_ax[i] <= r_sum_ax[i] + AW'(r_rate[i]);
                end
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.acc_pr) begin
                r_sum_pr[i_cmd.k] <= r_sum_pr[i_cmd.k] + PW'(w_sprod);
            end
            if (i_cmd.bias_wr) begin
                r_bias[i_cmd.j] <= RW'(w_bq);
            end
            if (i_cmd.clr_bias) begin
                for (int i = 0; i < 3; i++) begin
                    r_bias[i] <= '0;
                end
            end
            if (i_cmd.clr_sums) begin
                for (int i = 0; i < 3; i++) begin
                    r_sum_ax[i] <= '0;
                end
                for (int p = 0; p < 6; p++) begin
                    r_sum_pr[p] <= '0;
                end
                r_cnt <= '0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_rate[0] <= i_rate_x;
            r_rate[1] <= i_rate_y;
            r_rate[2] <= i_rate_z;
        end
        if (i_cmd.mul_start) begin
            r_neg <= w_neg;
        end
        if (i_cmd.ld_t1) begin
            r_t1 <= w_sprod;
        end
        if (i_cmd.ld_d) begin
            r_dmag <= w_dmag;
        end
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (i_cmd.acc_sq) begin
            r_acc <= r_acc + ((i_cmd.k >= K_CROSS) ? (w_prod << 1) : w_prod);
        end
        if (i_cmd.ld_nn) begin
            r_nn <= NNW'(w_prod);
        end
        if (i_cmd.ld_m) begin
            r_m <= MW'(w_prod);
        end
        if (i_cmd.load_out) begin
            for (int i = 0; i < 3; i++) begin
                r_body[i] <= i_cmd.body_en ? w_sat[i] : '0;
            end
            r_o_cal         <= i_cmd.cal;
            r_o_calibrating <= i_cmd.calibrating;
            r_o_coll        <= w_coll;
            r_o_fail        <= i_cmd.fail;
        end
    end

    assign o_body_x         = r_body[0];
    assign o_body_y         = r_body[1];
    assign o_body_z         = r_body[2];
    assign o_is_calibrated  = r_o_cal;
    assign o_is_calibrating = r_o_calibrating;
    assign o_collected      = r_o_coll;
    assign o_run_failed     = r_o_fail;

endmodule

[hw/rtl/gbc_ctrl.sv]
// Controller: sequences accumulate, covariance check, mean division and result handoff.
module gbc_ctrl import gbc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd,
    input  t_stat      i_stat
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ACC  = 5'd1;
    localparam logic [4:0] S_ACCW = 5'd2;
    localparam logic [4:0] S_T1   = 5'd3;
    localparam logic [4:0] S_T1W  = 5'd4;
    localparam logic [4:0] S_T2   = 5'd5;
    localparam logic [4:0] S_T2W  = 5'd6;
    localparam logic [4:0] S_SQ   = 5'd7;
    localparam logic [4:0] S_SQW  = 5'd8;
    localparam logic [4:0] S_NN   = 5'd9;
    localparam logic [4:0] S_NNW  = 5'd10;
    localparam logic [4:0] S_LM   = 5'd11;
    localparam logic [4:0] S_LMW  = 5'd12;
    localparam logic [4:0] S_MM   = 5'd13;
    localparam logic [4:0] S_MMW  = 5'd14;
    localparam logic [4:0] S_DIV  = 5'd15;
    localparam logic [4:0] S_DIVW = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    logic [4:0] r_state, n_state;
    logic [2:0] r_k, n_k;
    logic [1:0] r_j, n_j;
    logic       r_calibrating, n_calibrating;
    logic       r_calibrated, n_calibrated;
    logic       r_is_smp, n_is_smp;
    logic       r_fail, n_fail;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_j           = r_j;
        n_calibrating = r_calibrating;
        n_calibrated  = r_calibrated;
        n_is_smp      = r_is_smp;
        n_fail        = r_fail;
        o_cmd             = '0;
        o_cmd.k           = r_k;
        o_cmd.j           = r_j;
        o_cmd.body_en     = r_is_smp & r_calibrated;
        o_cmd.cal         = r_calibrated;
        o_cmd.calibrating = r_calibrating;
        o_cmd.fail        = r_fail;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_is_smp      = (i_func == FN_SAMPLE);
                    n_fail        = 1'b0;
                    n_state       = S_OUT;
                    case (i_func)
                        FN_ENABLE:  n_calibrating = 1'b1;
                        FN_DISABLE: n_calibrating = 1'b0;
                        FN_SAMPLE: begin
                            if (r_calibrating) begin
                                n_k     = K_FIRST;
                                n_state = S_ACC;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_ACC: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_RATE;
                o_cmd.add_axes  = (r_k == K_FIRST);
                n_state         = S_ACCW;
            end
            S_ACCW: begin
                if (i_stat.mul_done) begin
                    o_cmd.acc_pr = 1'b1;
                    if (r_k == K_LAST) begin
                        n_k = K_FIRST;
                        if (i_stat.n_ge2) begin
                            o_cmd.clr_acc = 1'b1;
                            n_state       = S_T1;
                        end else begin
                            n_state = S_OUT;
                        end
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = S_ACC;
                    end
                end
            end
            S_T1: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_T1;
                n_state         = S_T1W;
            end
            S_T1W: begin
                if (i_stat.mul_done) begin
                    o_cmd.ld_t1 = 1'b1;
                    n_state     = S_T2;
                end
            end
            S_T2: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_T2;
                n_state         = S_T2W;
            end
            S_T2W: begin
                if (i_stat.mul_done) begin
                    o_cmd.ld_d = 1'b1;
                    n_state    = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_SQ;
                n_state         = S_SQW;
            end
            S_SQW: begin
                if (i_stat.mul_done) begin
                    o_cmd.acc_sq = 1'b1;
                    if (r_k == K_LAST) begin
                        n_k     = K_FIRST;
                        n_state = S_NN;
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = S_T1;
                    end
                end
            end
            S_NN: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_NN;
                n_state         = S_NNW;
            end
            S_NNW: begin
                if (i_stat.mul_done) begin
                    o_cmd.ld_nn = 1'b1;
                    n_state     = S_LM;
                end
            end
            S_LM: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_LIM;
                n_state         = S_LMW;
            end
            S_LMW: begin
                if (i_stat.mul_done) begin
                    o_cmd.ld_m = 1'b1;
                    n_state    = S_MM;
                end
            end
            S_MM: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_MM;
                n_state         = S_MMW;
            end
            S_MMW: begin
                if (i_stat.mul_done) begin
                    if (i_stat.gt) begin
                        // variance too high: drop the run and start over
                        o_cmd.clr_sums = 1'b1;
                        o_cmd.clr_bias = 1'b1;
                        n_fail         = 1'b1;
                        n_calibrated   = 1'b0;
                        n_state        = S_OUT;
                    end else begin
                        n_j     = J_FIRST;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.bias_wr = 1'b1;
                    if (r_j == J_LAST) begin
                        n_state = S_OUT;
                        if (i_stat.n_full) begin
                            o_cmd.clr_sums = 1'b1;
                            n_calibrated   = 1'b1;
                            n_calibrating  = 1'b0;
                        end
                    end else begin
                        n_j     = r_j + 2'd1;
                        n_state = S_DIV;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_k           <= K_FIRST;
            r_j           <= J_FIRST;
            r_calibrating <= 1'b0;
            r_calibrated  <= 1'b0;
            r_is_smp      <= 1'b0;
            r_fail        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_k           <= n_k;
            r_j           <= n_j;
            r_calibrating <= n_calibrating;
            r_calibrated  <= n_calibrated;
            r_is_smp      <= n_is_smp;
            r_fail        <= n_fail;
            r_out_valid   <= n_out_valid;
        end
    end

endmodule

[hw/rtl/gyro_bias_calibrator_top.sv]
// Gyro static bias calibrator top level.
// i_in carries one beat per gyro sample (func 0, Q3.12 rates) or command
// (func 1 enables, func 2 disables calibration). Every input beat yields one
// result beat on o_out: sample rates bias-corrected once calibrated (else zeros),
// the calibrated/calibrating flags, the sample count of the current run and
// a flag for a sample that failed the covariance check. i_cfg writes the
// norm limit; write it only while no beat is in flight.
// A command or a sample taken while not calibrating goes from S_IDLE through
// S_OUT into the result register. A calibration sample runs six products
// through the shared 16-bit-digit multiplier. From the second sample on it
// also runs the covariance check (21 more products) and, if the check passes,
// three bit-serial mean divisions of 16+clog2(HISTORY_DEPTH+1) steps each.
// One item is in work at a time.
// The result register lets the next beat be accepted while a result waits;
// when the receiver stalls, the block holds its next result until o_out is
// taken. Reset clears sums, bias, count and flags and loads the default limit.
module gyro_bias_calibrator_top import gbc_pkg::*; #(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbc_in_if.sink     i_in,
    gbc_out_if.source  o_out,
    gbc_cfg_if.sink    i_cfg
);
    t_cmd  w_cmd;
    t_stat w_stat;

    assign i_cfg.ready = 1'b1;

    gbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_func      (i_in.func),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    gbc_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_rate_x         (i_in.rate_x),
        .i_rate_y         (i_in.rate_y),
        .i_rate_z         (i_in.rate_z),
        .i_cfg_we         (i_cfg.valid & i_cfg.ready),
        .i_cfg_data       (i_cfg.norm_limit),
        .o_body_x         (o_out.body_x),
        .o_body_y         (o_out.body_y),
        .o_body_z         (o_out.body_z),
        .o_is_calibrated  (o_out.is_calibrated),
        .o_is_calibrating (o_out.is_calibrating),
        .o_collected      (o_out.collected),
        .o_run_failed     (o_out.run_failed)
    );

    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_calibrated |->
            o_out.body_x == '0 && o_out.body_y == '0 && o_out.body_z == '0)
        else $error("uncalibrated result with nonzero rate");

    a_fail_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.run_failed |->
            !o_out.is_calibrated && o_out.is_calibrating && o_out.collected == 8'd0)
        else $error("failed check did not restart the run");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !o_out.valid || o_out.ready)
        else $error("result register overwritten while held");

    a_idle_no_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.mul_done |-> !i_in.ready)
        else $error("multiplier finished while controller idle");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the gyro bias calibrator: driver, monitor and predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gbc_pkg::*;

    localparam int HIST    = 128;
    localparam int RUN_LEN = 140;

    typedef struct {
        logic [1:0]         func;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
    } t_gyro_item;

    typedef struct {
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic               cal;
        logic               calib;
        logic [7:0]         cnt;
        logic               fail;
    } t_body_rate;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gbc_in_if  in_if();
    gbc_out_if out_if();
    gbc_cfg_if cfg_if();

    gyro_bias_calibrator_top #(.HISTORY_DEPTH(HIST)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #6 i_clk = ~i_clk;

    t_gyro_item pending_q[$];
    t_body_rate body_q[$];
    t_gyro_item cur_item;
    int         idle_mode = 0;   // 0 none, 1 sender 81%, 2 receiver 81%, 3 both 23%
    int         err_cnt = 0;
    int         hold_cnt = 0;
    bit         hold_tog = 1'b0;
    bit         hold_seen = 1'b0;

    // predictor state
    longint      ax_sum[3];
    longint      pr_sum[6];
    int          bias_v[3];
    int          n_seen;
    bit          calib_on;
    bit          calib_done;
    logic [31:0] lim_reg;
    int          n_samples, n_runs_ok, n_fails;

    initial begin
        in_if.valid = 1'b0;
        in_if.func = FN_SAMPLE;
        in_if.rate_x = '0;
        in_if.rate_y = '0;
        in_if.rate_z = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.norm_limit = '0;
    end

    function automatic void clear_sums();
        for (int i = 0; i < 3; i++) ax_sum[i] = 0;
        for (int i = 0; i < 6; i++) pr_sum[i] = 0;
        n_seen = 0;
    endfunction

    function automatic bit cov_exceeds(longint nn);
        int           ia[6] = '{0, 1, 2, 0, 0, 1};
        int           ib[6] = '{0, 1, 2, 1, 2, 2};
        logic [127:0] acc, lim, sq;
        logic [63:0]  mg, m;
        longint       d;
        acc = '0;
        for (int k = 0; k < 6; k++) begin
            d = nn * pr_sum[k] - ax_sum[ia[k]] * ax_sum[ib[k]];
            mg = (d < 0) ? -d : d;
            sq = {64'd0, mg} * {64'd0, mg};
            acc = acc + sq;
            if (k >= 3) acc = acc + sq;   // off-diagonal terms appear twice
        end
        m = {32'd0, lim_reg} * 64'(nn * (nn - 1));
        lim = {64'd0, m} * {64'd0, m};
        return acc > lim;
    endfunction

    function automatic t_body_rate calib_step(t_gyro_item it);
        t_body_rate r;
        int         rt[3];
        longint     nn;
        logic [63:0] mg;
        int         q, v;
        bit         failed;
        rt[0] = it.rx;
        rt[1] = it.ry;
        rt[2] = it.rz;
        failed = 1'b0;
        case (it.func)
            FN_ENABLE:  calib_on = 1'b1;
            FN_DISABLE: calib_on = 1'b0;
            FN_SAMPLE: begin
                if (calib_on) begin
                    n_samples++;
                    for (int i = 0; i < 3; i++) ax_sum[i] += rt[i];
                    pr_sum[0] += longint'(rt[0]) * rt[0];
                    pr_sum[1] += longint'(rt[1]) * rt[1];
                    pr_sum[2] += longint'(rt[2]) * rt[2];
                    pr_sum[3] += longint'(rt[0]) * rt[1];
                    pr_sum[4] += longint'(rt[0]) * rt[2];
                    pr_sum[5] += longint'(rt[1]) * rt[2];
                    n_seen++;
                    nn = n_seen;
                    if (nn >= 2) begin
                        if (cov_exceeds(nn)) begin
                            failed = 1'b1;
                            n_fails++;
                            clear_sums();
                            for (int i = 0; i < 3; i++) bias_v[i] = 0;
                            calib_done = 1'b0;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                mg = (ax_sum[i] < 0) ? -ax_sum[i] : ax_sum[i];
                                q = int'((mg + 64'(nn / 2)) / 64'(nn));
                                bias_v[i] = (ax_sum[i] < 0) ? -q : q;
                            end
                            if (nn >= HIST) begin
                                calib_done = 1'b1;
                                calib_on = 1'b0;
                                n_runs_ok++;
                                clear_sums();
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
            v = 0;
            if (it.func == FN_SAMPLE && calib_done) begin
                v = rt[i] - bias_v[i];
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end
            rt[i] = v;
        end
        r.bx = 16'(rt[0]);
        r.by = 16'(rt[1]);
        r.bz = 16'(rt[2]);
        r.cal = calib_done;
        r.calib = calib_on;
        r.cnt = (n_seen > 255) ? 8'd255 : 8'(n_seen);
        r.fail = failed;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) body_q.push_back(calib_step(cur_item));
            if (!in_if.valid || in_if.ready) begin
                if (pending_q.size() != 0 &&
                    !((idle_mode == 1 && $urandom_range(0, 99) < 81) ||
                      (idle_mode == 3 && $urandom_range(0, 99) < 23))) begin
                    cur_item = pending_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.func <= cur_item.func;
                    in_if.rate_x <= cur_item.rx;
                    in_if.rate_y <= cur_item.ry;
                    in_if.rate_z <= cur_item.rz;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, requested by toggling hold_tog
    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_cnt <= 600;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    task automatic chk(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_body_rate e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (body_q.size() == 0) begin
                    $error("result beat with no expected result pending");
                    err_cnt++;
                end else begin
                    e = body_q.pop_front();
                    chk("body_x", e.bx, out_if.body_x);
                    chk("body_y", e.by, out_if.body_y);
                    chk("body_z", e.bz, out_if.body_z);
                    chk("is_calibrated", e.cal, out_if.is_calibrated);
                    chk("is_calibrating", e.calib, out_if.is_calibrating);
                    chk("collected", e.cnt, out_if.collected);
                    chk("run_failed", e.fail, out_if.run_failed);
                end
            end
            out_if.ready <= !(hold_cnt > 0 ||
                              (idle_mode == 2 && $urandom_range(0, 99) < 81) ||
                              (idle_mode == 3 && $urandom_range(0, 99) < 23));
        end
    end

    function automatic void push_item(logic [1:0] f, int x, int y, int z);
        t_gyro_item it;
        it.func = f;
        it.rx = 16'(x);
        it.ry = 16'(y);
        it.rz = 16'(z);
        pending_q.push_back(it);
    endfunction

    function automatic int near_val(int base, int noise);
        int v;
        v = base + $urandom_range(0, 2 * noise) - noise;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic int any_rate();
        return int'($signed(16'($urandom_range(0, 65535))));
    endfunction

    // one calibration run: mostly steady samples, with some noise and breaks
    function automatic int gen_run();
        int bx, by, bz, noise, r, n;
        n = 0;
        bx = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 32000 : -32000)
                                         : $urandom_range(0, 8000) - 4000;
        by = $urandom_range(0, 8000) - 4000;
        bz = $urandom_range(0, 8000) - 4000;
        noise = (lim_reg == 0 || $urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 200);
        push_item(FN_ENABLE, any_rate(), any_rate(), any_rate());
        n++;
        for (int i = 0; i < RUN_LEN; i++) begin
            r = $urandom_range(0, 299);
            if (r < 3) begin
                push_item(FN_SAMPLE, any_rate(), any_rate(), any_rate());
            end else if (r < 6) begin
                push_item(FN_DISABLE, any_rate(), any_rate(), any_rate());
                push_item(FN_SAMPLE, near_val(bx, noise), by, bz);
                push_item(FN_ENABLE, any_rate(), any_rate(), any_rate());
                n += 2;
            end else if (r < 8) begin
                push_item(2'd3, any_rate(), any_rate(), any_rate());
            end else begin
                push_item(FN_SAMPLE, near_val(bx, noise), near_val(by, noise),
                          near_val(bz, noise));
            end
            n++;
        end
        for (int i = 0; i < 10; i++) begin
            push_item(FN_SAMPLE, any_rate(), any_rate(), any_rate());
            n++;
        end
        return n;
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_q.size() != 0 || in_if.valid || body_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.norm_limit <= v;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        lim_reg = v;
    endtask

    initial begin
        int cnt;
        logic [31:0] lim_plan[8];
        clear_sums();
        for (int i = 0; i < 3; i++) bias_v[i] = 0;
        calib_on = 1'b0;
        calib_done = 1'b0;
        lim_reg = NORM_LIMIT_RST;
        n_samples = 0;
        n_runs_ok = 0;
        n_fails = 0;
        lim_plan = '{NORM_LIMIT_RST, 32'hFFFF_FFFF, 32'd0, $urandom,
                     32'd1677722, $urandom_range(1000, 5000000), 32'd1, $urandom};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle samples, unused code, first-sample, failed check,
        // enable while calibrating, disable keeping partial sums
        push_item(FN_SAMPLE, 32767, -32768, 0);
        push_item(2'd3, -1, 1, -32768);
        push_item(FN_DISABLE, 0, 0, 0);
        push_item(FN_ENABLE, 0, 0, 0);
        push_item(FN_ENABLE, 5, 5, 5);
        push_item(FN_SAMPLE, 32767, -32768, 0);
        push_item(FN_SAMPLE, -32768, 32767, -1);
        push_item(FN_SAMPLE, 100, -200, 300);
        push_item(FN_SAMPLE, 100, -200, 300);
        push_item(FN_SAMPLE, 101, -199, 299);
        push_item(FN_DISABLE, 0, 0, 0);
        push_item(FN_SAMPLE, 7000, 7000, 7000);
        push_item(FN_ENABLE, 0, 0, 0);
        push_item(FN_SAMPLE, 100, -200, 300);
        push_item(FN_SAMPLE, -32768, -32768, -32768);
        push_item(FN_SAMPLE, 32767, 32767, 32767);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            idle_mode = ph % 4;
            if (ph > 0) write_limit(lim_plan[ph]);
            cnt = 0;
            while (cnt < 250) begin
                cnt += gen_run();
                if (ph == 5) wait_drained();   // sender waits for all results
            end
            if (ph == 4) begin
                repeat (40) @(posedge i_clk);
                hold_tog = ~hold_tog;
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d calibration samples over 8 limit settings and 4 idle patterns.",
                 n_samples);
        $display("Runs completed: %0d, variance check failures: %0d.", n_runs_ok, n_fails);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[gyro_bias_calibrator_top.f]
hw/rtl/gbc_pkg.sv
hw/rtl/gbc_if.sv
hw/rtl/gbc_mul.sv
hw/rtl/gbc_div.sv
hw/rtl/gbc_dp.sv
hw/rtl/gbc_ctrl.sv
hw/rtl/gyro_bias_calibrator_top.sv
dv/tb_top.sv
